// File: hw/rtl/assert_macros.svh
// assertion macros shared by the blend rtl
// relies on a clock named clock and an active-high reset named reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/gpab_pkg.sv
// constants and types for the gamma-2 premultiplied alpha blend
// used by gpab_linear, gpab_root and gamma2_premultiplied_alpha_blend
package gpab_pkg;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned GA_W       = 9;
   localparam int unsigned LANES      = 3;
   localparam int unsigned SQ_W       = 2 * PIX_W;
   localparam int unsigned PROD_W     = 2 * SQ_W;
   localparam int unsigned N_W        = PROD_W + 1;
   localparam int unsigned M_W        = 3 * PIX_W;
   localparam int unsigned ALPHA_MAX  = 255;
   localparam int unsigned ALPHA_ONE_Q8 = 256;
   localparam int unsigned DENOM      = ALPHA_MAX * ALPHA_ONE_Q8;
   localparam int unsigned HALF_DENOM = DENOM / 2;
   localparam int unsigned LIN_STAGES = 4;
   localparam int unsigned ROOT_STEPS = PIX_W;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_GLOBAL_ALPHA = 1'b0
   } gpab_reg_type;

   typedef logic [LANES-1:0][PIX_W-1:0] gpab_color_type;

   // linear-light sums per color lane plus the alpha quotient estimate
   typedef struct packed {
      logic [LANES-1:0][N_W-1:0] lin;
      logic [SQ_W-1:0]           alpha_y;
      logic [PIX_W-1:0]          alpha_q0;
   } gpab_lin_type;

   // one square-root pipeline stage
   typedef struct packed {
      logic [LANES-1:0][N_W-1:0] lin;
      gpab_color_type            root;
      logic [PIX_W-1:0]          alpha;
   } gpab_root_type;

endpackage

// File: hw/rtl/gpab_linear.sv
// front half of the blend: squares, products and linear-light sums, four stages
// depends on gpab_pkg
module gpab_linear (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [gpab_pkg::PIX_W-1:0]    src_alpha,
   input  gpab_pkg::gpab_color_type      src_color,
   input  logic [gpab_pkg::PIX_W-1:0]    dst_alpha,
   input  gpab_pkg::gpab_color_type      dst_color,
   input  logic [gpab_pkg::GA_W-1:0]     global_alpha,
   output logic                          out_valid,
   output gpab_pkg::gpab_lin_type        out_data
);

   localparam int unsigned PIX_W  = gpab_pkg::PIX_W;
   localparam int unsigned GA_W   = gpab_pkg::GA_W;
   localparam int unsigned LANES  = gpab_pkg::LANES;
   localparam int unsigned SQ_W   = gpab_pkg::SQ_W;
   localparam int unsigned PROD_W = gpab_pkg::PROD_W;
   localparam int unsigned N_W    = gpab_pkg::N_W;
   localparam int unsigned M_W    = gpab_pkg::M_W;
   localparam int unsigned X_W    = M_W + 1;
   localparam int unsigned AG_W   = PIX_W + GA_W;
   localparam int unsigned STAGES = gpab_pkg::LIN_STAGES;

   logic [STAGES-1:0] vld_ff;

   // stage 1
   logic [GA_W-1:0]             g_eff;
   logic [AG_W-1:0]             ag_full;
   logic [AG_W-1:0]             g255_full;
   logic [SQ_W-1:0]             ag1_in, ag1_ff;
   logic [SQ_W-1:0]             g255_1_in, g255_1_ff;
   logic [LANES-1:0][SQ_W-1:0]  s2_1_in, s2_1_ff;
   logic [LANES-1:0][SQ_W-1:0]  d2_1_in, d2_1_ff;
   logic [PIX_W-1:0]            da1_ff;

   // stage 2
   logic [SQ_W-1:0]             wd;
   logic [PIX_W-1:0]            inv_da;
   logic [LANES-1:0][PROD_W-1:0] td2_in, td2_ff;
   logic [LANES-1:0][PROD_W-1:0] ts2_in, ts2_ff;
   logic [M_W-1:0]              m1_2_in, m1_2_ff;
   logic [M_W-1:0]              m2_2_in, m2_2_ff;

   // stage 3
   logic [LANES-1:0][N_W-1:0]   n3_in, n3_ff;
   logic [X_W-1:0]              x3;
   logic [SQ_W-1:0]             y3_in, y3_ff;

   // stage 4
   logic [M_W-1:0]              yq;
   logic [PIX_W-1:0]            q4_in, q4_ff;
   logic [LANES-1:0][N_W-1:0]   n4_ff;
   logic [SQ_W-1:0]             y4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_comb begin
      g_eff = (global_alpha > GA_W'(gpab_pkg::ALPHA_ONE_Q8)) ?
              GA_W'(gpab_pkg::ALPHA_ONE_Q8) : global_alpha;
      ag_full   = AG_W'(src_alpha) * AG_W'(g_eff);
      ag1_in    = ag_full[SQ_W-1:0];
      g255_full = (AG_W'(g_eff) << PIX_W) - AG_W'(g_eff);
      g255_1_in = g255_full[SQ_W-1:0];
      for (int l = 0; l < LANES; l++) begin
         s2_1_in[l] = SQ_W'(src_color[l]) * SQ_W'(src_color[l]);
         d2_1_in[l] = SQ_W'(dst_color[l]) * SQ_W'(dst_color[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ag1_ff    <= ag1_in;
         g255_1_ff <= g255_1_in;
         s2_1_ff   <= s2_1_in;
         d2_1_ff   <= d2_1_in;
         da1_ff    <= dst_alpha;
      end
   end

   always_comb begin
      wd     = SQ_W'(gpab_pkg::DENOM) - ag1_ff;
      inv_da = PIX_W'(gpab_pkg::ALPHA_MAX) - da1_ff;
      for (int l = 0; l < LANES; l++) begin
         td2_in[l] = PROD_W'(wd) * PROD_W'(d2_1_ff[l]);
         ts2_in[l] = PROD_W'(g255_1_ff) * PROD_W'(s2_1_ff[l]);
      end
      m1_2_in = M_W'(ag1_ff) * M_W'(inv_da);
      m2_2_in = (M_W'(da1_ff) << SQ_W) - (M_W'(da1_ff) << PIX_W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         td2_ff  <= td2_in;
         ts2_ff  <= ts2_in;
         m1_2_ff <= m1_2_in;
         m2_2_ff <= m2_2_in;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         n3_in[l] = N_W'(td2_ff[l]) + N_W'(ts2_ff[l]);
      end
      x3    = X_W'(m1_2_ff) + X_W'(m2_2_ff) + X_W'(gpab_pkg::HALF_DENOM);
      y3_in = x3[M_W-1:PIX_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n3_ff <= n3_in;
         y3_ff <= y3_in;
      end
   end

   // y / 255 estimated as y * 257 / 65536, low by at most one
   always_comb begin
      yq    = (M_W'(y3_ff) << PIX_W) + M_W'(y3_ff);
      q4_in = yq[M_W-1:SQ_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n4_ff <= n3_ff;
         y4_ff <= y3_ff;
         q4_ff <= q4_in;
      end
   end

   assign out_valid         = vld_ff[STAGES-1];
   assign out_data.lin      = n4_ff;
   assign out_data.alpha_y  = y4_ff;
   assign out_data.alpha_q0 = q4_ff;

endmodule

// File: hw/rtl/gpab_root.sv
// back half of the blend: alpha quotient fix and one root bit per stage per lane
// depends on gpab_pkg and assert_macros.svh
`include "assert_macros.svh"

module gpab_root (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  gpab_pkg::gpab_lin_type     in_data,
   output logic                       out_valid,
   output gpab_pkg::gpab_color_type   out_color,
   output logic [gpab_pkg::PIX_W-1:0] out_alpha
);

   localparam int unsigned PIX_W  = gpab_pkg::PIX_W;
   localparam int unsigned LANES  = gpab_pkg::LANES;
   localparam int unsigned SQ_W   = gpab_pkg::SQ_W;
   localparam int unsigned N_W    = gpab_pkg::N_W;
   localparam int unsigned CMP_W  = N_W + 2;
   localparam int unsigned T_W    = PIX_W + 1;
   localparam int unsigned T2_W   = 2 * T_W;
   localparam int unsigned STEPS  = gpab_pkg::ROOT_STEPS;

   gpab_pkg::gpab_root_type stg_ff [STEPS];
   logic [STEPS-1:0]        vld_ff;

   logic [SQ_W-1:0]  q0_prod;
   logic [SQ_W-1:0]  alpha_rem;
   logic [PIX_W:0]   alpha_q;
   logic [PIX_W-1:0] alpha_fix;

   // exact alpha quotient from the estimate
   always_comb begin
      q0_prod   = (SQ_W'(in_data.alpha_q0) << PIX_W) - SQ_W'(in_data.alpha_q0);
      alpha_rem = in_data.alpha_y - q0_prod;
      alpha_q   = (PIX_W+1)'(in_data.alpha_q0) +
                  (PIX_W+1)'(alpha_rem >= SQ_W'(gpab_pkg::ALPHA_MAX));
      alpha_fix = alpha_q[PIX_W] ? PIX_W'(gpab_pkg::ALPHA_MAX) : alpha_q[PIX_W-1:0];
   end

   genvar j;
   generate
      for (j = 0; j < STEPS; j++) begin : g_step
         localparam logic [PIX_W-1:0] TRY_BIT = PIX_W'(1) << (STEPS - 1 - j);

         gpab_pkg::gpab_root_type       prev_st;
         gpab_pkg::gpab_root_type       stg_in;
         logic                          prev_vld;
         logic [LANES-1:0][PIX_W-1:0]   cand;
         logic [LANES-1:0][T_W-1:0]     t;
         logic [LANES-1:0][T2_W-1:0]    t2;
         logic [LANES-1:0][CMP_W-1:0]   lhs;
         logic [LANES-1:0][CMP_W-1:0]   rhs;

         if (j == 0) begin : g_first
            assign prev_st.lin   = in_data.lin;
            assign prev_st.root  = '0;
            assign prev_st.alpha = alpha_fix;
            assign prev_vld      = in_valid;
         end else begin : g_next
            assign prev_st  = stg_ff[j-1];
            assign prev_vld = vld_ff[j-1];
         end

         // keep the bit when (2r-1)^2 * 65280 <= 4n
         always_comb begin
            stg_in = prev_st;
            for (int l = 0; l < LANES; l++) begin
               cand[l] = prev_st.root[l] | TRY_BIT;
               t[l]    = {cand[l], 1'b0} - T_W'(1);
               t2[l]   = T2_W'(t[l]) * T2_W'(t[l]);
               lhs[l]  = (CMP_W'(t2[l]) << SQ_W) - (CMP_W'(t2[l]) << PIX_W);
               rhs[l]  = {prev_st.lin[l], 2'b00};
               if (lhs[l] <= rhs[l]) begin
                  stg_in.root[l] = cand[l];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[j] <= 1'b0;
            end else if (en) begin
               vld_ff[j] <= prev_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               stg_ff[j] <= stg_in;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[STEPS-1];
   assign out_color = stg_ff[STEPS-1].root;
   assign out_alpha = stg_ff[STEPS-1].alpha;

   `ASSERT_CLK(a_alpha_estimate_off_by_one, in_valid && en |-> alpha_rem < 16'd510, "alpha quotient estimate off by more than one")

endmodule

// File: hw/rtl/gamma2_premultiplied_alpha_blend.sv
// gamma-2 premultiplied over blend of one ARGB8888 source onto one destination pixel
// pipeline: 4 arithmetic stages, then 8 root stages, between transaction accept and rsp_valid
// throughput: one transaction per cycle; a stalled rsp side freezes the whole pipeline
// reset: synchronous active high, empties the pipeline and sets global_alpha to 256
// depends on gpab_pkg, gpab_linear, gpab_root and assert_macros.svh
`include "assert_macros.svh"

module gamma2_premultiplied_alpha_blend (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gpab_pkg::PIX_W-1:0]        req_src_alpha,
   input  logic [gpab_pkg::PIX_W-1:0]        req_src_red,
   input  logic [gpab_pkg::PIX_W-1:0]        req_src_green,
   input  logic [gpab_pkg::PIX_W-1:0]        req_src_blue,
   input  logic [gpab_pkg::PIX_W-1:0]        req_dst_alpha,
   input  logic [gpab_pkg::PIX_W-1:0]        req_dst_red,
   input  logic [gpab_pkg::PIX_W-1:0]        req_dst_green,
   input  logic [gpab_pkg::PIX_W-1:0]        req_dst_blue,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gpab_pkg::PIX_W-1:0]        rsp_out_alpha,
   output logic [gpab_pkg::PIX_W-1:0]        rsp_out_red,
   output logic [gpab_pkg::PIX_W-1:0]        rsp_out_green,
   output logic [gpab_pkg::PIX_W-1:0]        rsp_out_blue,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gpab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gpab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gpab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned GA_W       = gpab_pkg::GA_W;
   localparam int unsigned CSR_ADDR_W = gpab_pkg::CSR_ADDR_W;
   localparam int unsigned CSR_DATA_W = gpab_pkg::CSR_DATA_W;

   logic [GA_W-1:0]              global_alpha_ff, global_alpha_in;
   logic [CSR_ADDR_W-3:0]        csr_word;
   logic                         csr_wr;
   logic                         en;
   gpab_pkg::gpab_color_type     src_color, dst_color, out_color;
   logic                         lin_valid;
   gpab_pkg::gpab_lin_type       lin_data;

   // register file
   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      global_alpha_in = global_alpha_ff;
      if (csr_wr && (csr_word == gpab_pkg::REG_GLOBAL_ALPHA)) begin
         global_alpha_in = csr_pwdata[GA_W-1:0];
      end
      csr_prdata = (csr_word == gpab_pkg::REG_GLOBAL_ALPHA) ?
                   CSR_DATA_W'(global_alpha_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_alpha_ff <= GA_W'(gpab_pkg::ALPHA_ONE_Q8);
      end else begin
         global_alpha_ff <= global_alpha_in;
      end
   end

   // pipeline moves whenever the output register is free or being drained
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign src_color = {req_src_blue, req_src_green, req_src_red};
   assign dst_color = {req_dst_blue, req_dst_green, req_dst_red};

   gpab_linear u_linear (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .src_alpha    (req_src_alpha),
      .src_color    (src_color),
      .dst_alpha    (req_dst_alpha),
      .dst_color    (dst_color),
      .global_alpha (global_alpha_ff),
      .out_valid    (lin_valid),
      .out_data     (lin_data)
   );

   gpab_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lin_valid),
      .in_data   (lin_data),
      .out_valid (rsp_valid),
      .out_color (out_color),
      .out_alpha (rsp_out_alpha)
   );

   assign rsp_out_red   = out_color[0];
   assign rsp_out_green = out_color[1];
   assign rsp_out_blue  = out_color[2];

   `ASSERT_CLK(a_stall_blocks_req, rsp_valid && !rsp_ready |-> !req_ready, "transaction accepted while output stalled")
   `ASSERT_CLK_ALWAYS(a_reset_opaque, reset |=> global_alpha_ff == 9'd256, "global alpha not opaque after reset")
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "pipeline not empty after reset")

endmodule
